// File: rtl/tilt_pkg.sv
// ----------------------------------------------------------------------------
// tilt_pkg
// shared types, widths and the arctangent table of the tilt angle pipeline
// ----------------------------------------------------------------------------
package tilt_pkg;

    localparam int LANES        = 3;
    localparam int SQRT_STEPS   = 32;
    localparam int NORM_STEPS   = 6;
    localparam int CORDIC_STEPS = 32;

    localparam int AXIS_W = 16;     // magnitude of one axis
    localparam int SQ_W   = 31;     // square of one magnitude
    localparam int RAD_W  = 64;     // radicand, sum of squares times 2^32
    localparam int ROOT_W = 32;     // rounded root
    localparam int OP_W   = 41;     // normalized vector operand
    localparam int CX_W   = 44;     // cordic x and y, signed
    localparam int ACC_W  = 42;     // cordic angle accumulator, signed
    localparam int ANG_W  = 40;     // angle in 1e-10 degree, 0 to 90 degrees
    localparam int DIV_W  = 34;     // width of the scale divisor

    localparam logic [ANG_W-1:0] DEG90_E10 = 40'd900000000000;
    localparam logic [DIV_W-1:0] HALF_E10  = 34'd5000000000;
    localparam logic [DIV_W-1:0] ONE_E10   = 34'd10000000000;

    // per-item control carried beside the payload
    typedef struct packed {
        logic             vld;
        logic [LANES-1:0] neg;
        logic             undef;
        logic [LANES-1:0] numz;
        logic [LANES-1:0] denz;
    } ctl_t;

    // atan(2^-i) in 1e-10 degree
    function automatic logic [ANG_W-1:0] atan_e10(input int unsigned idx);
        logic [ANG_W-1:0] v;
        case (idx)
            0:       v = 40'd450000000000;
            1:       v = 40'd265650511771;
            2:       v = 40'd140362434679;
            3:       v = 40'd71250163489;
            4:       v = 40'd35763343750;
            5:       v = 40'd17899106082;
            6:       v = 40'd8951737102;
            7:       v = 40'd4476141709;
            8:       v = 40'd2238105004;
            9:       v = 40'd1119056771;
            10:      v = 40'd559528919;
            11:      v = 40'd279764526;
            12:      v = 40'd139882271;
            13:      v = 40'd69941137;
            14:      v = 40'd34970569;
            15:      v = 40'd17485284;
            16:      v = 40'd8742642;
            17:      v = 40'd4371321;
            18:      v = 40'd2185661;
            19:      v = 40'd1092830;
            20:      v = 40'd546415;
            21:      v = 40'd273208;
            22:      v = 40'd136604;
            23:      v = 40'd68302;
            24:      v = 40'd34151;
            25:      v = 40'd17075;
            26:      v = 40'd8538;
            27:      v = 40'd4269;
            28:      v = 40'd2134;
            29:      v = 40'd1067;
            30:      v = 40'd534;
            31:      v = 40'd267;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/tilt_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tilt_sqrt_cell
// one digit of the bitwise square root, registered
// ----------------------------------------------------------------------------
module tilt_sqrt_cell
    import tilt_pkg::*;
#(
    parameter int STEP = 31
)
(
    input  logic              clk,
    input  logic [RAD_W-1:0]  rem_in,
    input  logic [RAD_W-1:0]  root_in,
    input  logic [AXIS_W-1:0] aux_in,
    output logic [RAD_W-1:0]  rem_reg,
    output logic [RAD_W-1:0]  root_reg,
    output logic [AXIS_W-1:0] aux_reg
);

    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * STEP);

    logic [RAD_W-1:0] trial;
    logic [RAD_W-1:0] rem_next;
    logic [RAD_W-1:0] root_next;

    always_comb
    begin
        trial = root_in + BIT;
        if (rem_in >= trial)
        begin
            rem_next  = rem_in - trial;
            root_next = (root_in >> 1) + BIT;
        end
        else
        begin
            rem_next  = rem_in;
            root_next = root_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        aux_reg  <= aux_in;
    end

endmodule

// File: rtl/tilt_norm_cell.sv
// ----------------------------------------------------------------------------
// tilt_norm_cell
// one step of the normalizing shift of a vector pair, registered
// ----------------------------------------------------------------------------
module tilt_norm_cell
    import tilt_pkg::*;
#(
    parameter int SH = 32
)
(
    input  logic            clk,
    input  logic [OP_W-1:0] num_in,
    input  logic [OP_W-1:0] den_in,
    output logic [OP_W-1:0] num_reg,
    output logic [OP_W-1:0] den_reg
);

    logic top_clear;

    // shift when the top bits of both operands are clear
    assign top_clear = ((num_in | den_in) >> (OP_W - SH)) == '0;

    always_ff @(posedge clk)
    begin
        num_reg <= top_clear ? (num_in << SH) : num_in;
        den_reg <= top_clear ? (den_in << SH) : den_in;
    end

endmodule

// File: rtl/tilt_cordic_cell.sv
// ----------------------------------------------------------------------------
// tilt_cordic_cell
// one vectoring iteration of the arctangent cordic, registered
// ----------------------------------------------------------------------------
module tilt_cordic_cell
    import tilt_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic                    clk,
    input  logic signed [CX_W-1:0]  x_in,
    input  logic signed [CX_W-1:0]  y_in,
    input  logic signed [ACC_W-1:0] acc_in,
    output logic signed [CX_W-1:0]  x_reg,
    output logic signed [CX_W-1:0]  y_reg,
    output logic signed [ACC_W-1:0] acc_reg
);

    localparam logic signed [ACC_W-1:0] ATAN = ACC_W'(atan_e10(STEP));

    logic signed [CX_W-1:0] dx;
    logic signed [CX_W-1:0] dy;

    assign dx = y_in >>> STEP;
    assign dy = x_in >>> STEP;

    always_ff @(posedge clk)
    begin
        if (y_in > 0)
        begin
            x_reg   <= x_in + dx;
            y_reg   <= y_in - dy;
            acc_reg <= acc_in + ATAN;
        end
        else
        begin
            x_reg   <= x_in - dx;
            y_reg   <= y_in + dy;
            acc_reg <= acc_in - ATAN;
        end
    end

endmodule

// File: rtl/tilt_div_cell.sv
// ----------------------------------------------------------------------------
// tilt_div_cell
// one quotient bit of the division by 1e10, registered
// ----------------------------------------------------------------------------
module tilt_div_cell
    import tilt_pkg::*;
#(
    parameter int NUM_W = 48,
    parameter int Q_W   = 15,
    parameter int STEP  = 0
)
(
    input  logic             clk,
    input  logic [NUM_W-1:0] rem_in,
    input  logic [Q_W-1:0]   q_in,
    output logic [NUM_W-1:0] rem_reg,
    output logic [Q_W-1:0]   q_reg
);

    localparam logic [NUM_W-1:0] DSH = NUM_W'(ONE_E10) << STEP;

    always_ff @(posedge clk)
    begin
        if (rem_in >= DSH)
        begin
            rem_reg <= rem_in - DSH;
            q_reg   <= q_in | (Q_W'(1) << STEP);
        end
        else
        begin
            rem_reg <= rem_in;
            q_reg   <= q_in;
        end
    end

endmodule

// File: rtl/accel_tilt_angles.sv
// the done strobe follows the accepting edge through one chain: the capture, square
//   and sum stages, 32 root cells, a rounding stage, 6 shift cells, 32 cordic cells,
//   a scaling stage, ANGLE_FRAC_BITS + 7 divide cells and the output stage
// throughput: one sample per cycle, busy stays low
// reset clears only the control line of the pipeline; results cannot be stalled
// ----------------------------------------------------------------------------
// accel_tilt_angles
// tilt angles of a three-axis accelerometer sample, fully pipelined
// ----------------------------------------------------------------------------
module accel_tilt_angles
    import tilt_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] acc_x,
    input  logic signed [15:0] acc_y,
    input  logic signed [15:0] acc_z,
    output logic               done,
    output logic signed [15:0] tilt_x,
    output logic signed [15:0] tilt_y,
    output logic signed [15:0] tilt_z,
    output logic               undefined_flag
);

    // quotient width: 90 * 2^F stays below 2^(F+7)
    localparam int QB    = ANGLE_FRAC_BITS + 7;
    // scaled angle plus half fits in 40 + F bits
    localparam int NUM_W = ANG_W + ANGLE_FRAC_BITS;
    // stage map of the chain
    localparam int ST_SQRT  = 3;
    localparam int ST_ROUND = ST_SQRT + SQRT_STEPS;
    localparam int ST_NORM  = ST_ROUND + 1;
    localparam int ST_CRD   = ST_NORM + NORM_STEPS;
    localparam int ST_SCALE = ST_CRD + CORDIC_STEPS;
    localparam int ST_DIV   = ST_SCALE + 1;
    localparam int ST_OUT   = ST_DIV + QB;
    localparam int LAT      = ST_OUT + 1;

    // control line, one entry per stage
    ctl_t ctl_reg [LAT];
    ctl_t ctl_next;

    // input stage
    logic signed [15:0] axis_reg [LANES];
    logic [AXIS_W-1:0]  ab       [LANES];

    // squares and sums
    logic [SQ_W-1:0]   sq_reg  [LANES];
    logic [AXIS_W-1:0] ab1_reg [LANES];
    logic [RAD_W-1:0]  rad_reg [LANES];
    logic [AXIS_W-1:0] ab2_reg [LANES];

    // root chain
    logic [RAD_W-1:0]  sq_rem  [SQRT_STEPS+1][LANES];
    logic [RAD_W-1:0]  sq_root [SQRT_STEPS+1][LANES];
    logic [AXIS_W-1:0] sq_aux  [SQRT_STEPS+1][LANES];

    // root rounding and operand pick
    logic [ROOT_W-1:0] root_fin [LANES];
    logic [OP_W-1:0]   num_reg  [LANES];
    logic [OP_W-1:0]   den_reg  [LANES];

    // shift chain
    logic [OP_W-1:0] nm_num [NORM_STEPS+1][LANES];
    logic [OP_W-1:0] nm_den [NORM_STEPS+1][LANES];

    // cordic chain
    logic signed [CX_W-1:0]  cr_x   [CORDIC_STEPS+1][LANES];
    logic signed [CX_W-1:0]  cr_y   [CORDIC_STEPS+1][LANES];
    logic signed [ACC_W-1:0] cr_acc [CORDIC_STEPS+1][LANES];

    // scaling and division chain
    logic [ANG_W-1:0] ang     [LANES];
    logic [NUM_W-1:0] dv_rem  [QB+1][LANES];
    logic [QB-1:0]    dv_q    [QB+1][LANES];
    logic [15:0]      mag     [LANES];
    logic [15:0]      res_reg [LANES];
    logic             undef_reg;

    // no back-pressure anywhere, every cycle takes a transfer
    assign busy = 1'b0;

    // control for a new sample: signs and the zero cases are known up front
    always_comb
    begin
        ctl_next.vld     = start && !busy;
        ctl_next.neg     = {acc_z[15], acc_y[15], acc_x[15]};
        ctl_next.undef   = (acc_x == '0) && (acc_y == '0) && (acc_z == '0);
        // numerator zero: x, y, and the root of x and y
        ctl_next.numz[0] = (acc_x == '0);
        ctl_next.numz[1] = (acc_y == '0);
        ctl_next.numz[2] = (acc_x == '0) && (acc_y == '0);
        // denominator zero: the roots for x and y, and z itself
        ctl_next.denz[0] = (acc_y == '0) && (acc_z == '0);
        ctl_next.denz[1] = (acc_x == '0) && (acc_z == '0);
        ctl_next.denz[2] = (acc_z == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else
        begin
            ctl_reg[0] <= ctl_next;
            for (int i = 1; i < LAT; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    // stage 0: sample capture
    always_ff @(posedge clk)
    begin
        axis_reg[0] <= acc_x;
        axis_reg[1] <= acc_y;
        axis_reg[2] <= acc_z;
    end

    // magnitudes; the most negative sample maps to 32768, which still fits
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            ab[l] = axis_reg[l][15] ? AXIS_W'(16'd0 - axis_reg[l]) : AXIS_W'(axis_reg[l]);
        end
    end

    // stage 1: squares, one multiplier per axis
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            sq_reg[l]  <= SQ_W'(ab[l]) * SQ_W'(ab[l]);
            ab1_reg[l] <= ab[l];
        end
    end

    // stage 2: radicands, the other two squares of each lane times 2^32
    always_ff @(posedge clk)
    begin
        rad_reg[0] <= {(32'(sq_reg[1]) + 32'(sq_reg[2])), 32'd0};
        rad_reg[1] <= {(32'(sq_reg[0]) + 32'(sq_reg[2])), 32'd0};
        rad_reg[2] <= {(32'(sq_reg[0]) + 32'(sq_reg[1])), 32'd0};
        for (int l = 0; l < LANES; l++)
        begin
            ab2_reg[l] <= ab1_reg[l];
        end
    end

    // root chain, one result bit per cell from the top digit down
    genvar gl, gj;
    generate
        for (gl = 0; gl < LANES; gl++)
        begin : g_sqrt_lane
            assign sq_rem[0][gl]  = rad_reg[gl];
            assign sq_root[0][gl] = '0;
            assign sq_aux[0][gl]  = ab2_reg[gl];
            for (gj = 0; gj < SQRT_STEPS; gj++)
            begin : g_cell
                tilt_sqrt_cell #(
                    .STEP (SQRT_STEPS - 1 - gj)
                ) u_cell (
                    .clk      (clk),
                    .rem_in   (sq_rem[gj][gl]),
                    .root_in  (sq_root[gj][gl]),
                    .aux_in   (sq_aux[gj][gl]),
                    .rem_reg  (sq_rem[gj+1][gl]),
                    .root_reg (sq_root[gj+1][gl]),
                    .aux_reg  (sq_aux[gj+1][gl])
                );
            end
        end
    endgenerate

    // round the root to nearest
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            root_fin[l] = sq_root[SQRT_STEPS][l][ROOT_W-1:0]
                        + ROOT_W'(sq_rem[SQRT_STEPS][l] > sq_root[SQRT_STEPS][l]);
        end
    end

    // x and y lanes: axis over root; z lane: root over axis
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES - 1; l++)
        begin
            num_reg[l] <= OP_W'({sq_aux[SQRT_STEPS][l], 16'd0});
            den_reg[l] <= OP_W'(root_fin[l]);
        end
        num_reg[LANES-1] <= OP_W'(root_fin[LANES-1]);
        den_reg[LANES-1] <= OP_W'({sq_aux[SQRT_STEPS][LANES-1], 16'd0});
    end

    // normalize so the leading one of the pair lands on the top bit
    generate
        for (gl = 0; gl < LANES; gl++)
        begin : g_norm_lane
            assign nm_num[0][gl] = num_reg[gl];
            assign nm_den[0][gl] = den_reg[gl];
            for (gj = 0; gj < NORM_STEPS; gj++)
            begin : g_cell
                tilt_norm_cell #(
                    .SH (32 >> gj)
                ) u_cell (
                    .clk     (clk),
                    .num_in  (nm_num[gj][gl]),
                    .den_in  (nm_den[gj][gl]),
                    .num_reg (nm_num[gj+1][gl]),
                    .den_reg (nm_den[gj+1][gl])
                );
            end
        end
    endgenerate

    // vectoring cordic, the angle gathers in the accumulator
    generate
        for (gl = 0; gl < LANES; gl++)
        begin : g_cordic_lane
            assign cr_x[0][gl]   = CX_W'(nm_den[NORM_STEPS][gl]);
            assign cr_y[0][gl]   = CX_W'(nm_num[NORM_STEPS][gl]);
            assign cr_acc[0][gl] = '0;
            for (gj = 0; gj < CORDIC_STEPS; gj++)
            begin : g_cell
                tilt_cordic_cell #(
                    .STEP (gj)
                ) u_cell (
                    .clk     (clk),
                    .x_in    (cr_x[gj][gl]),
                    .y_in    (cr_y[gj][gl]),
                    .acc_in  (cr_acc[gj][gl]),
                    .x_reg   (cr_x[gj+1][gl]),
                    .y_reg   (cr_y[gj+1][gl]),
                    .acc_reg (cr_acc[gj+1][gl])
                );
            end
        end
    endgenerate

    // clamp to 0..90 degrees and apply the zero numerator and denominator cases
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (ctl_reg[ST_SCALE-1].numz[l])
            begin
                ang[l] = '0;
            end
            else if (ctl_reg[ST_SCALE-1].denz[l])
            begin
                ang[l] = DEG90_E10;
            end
            else if (cr_acc[CORDIC_STEPS][l] < 0)
            begin
                ang[l] = '0;
            end
            else if (cr_acc[CORDIC_STEPS][l] > $signed(ACC_W'(DEG90_E10)))
            begin
                ang[l] = DEG90_E10;
            end
            else
            begin
                ang[l] = cr_acc[CORDIC_STEPS][l][ANG_W-1:0];
            end
        end
    end

    // scale by 2^F and add half a unit for rounding
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            dv_rem[0][l] <= (NUM_W'(ang[l]) << ANGLE_FRAC_BITS) + NUM_W'(HALF_E10);
        end
    end

    // restoring division by 1e10, one quotient bit per cell
    generate
        for (gl = 0; gl < LANES; gl++)
        begin : g_div_lane
            assign dv_q[0][gl] = '0;
            for (gj = 0; gj < QB; gj++)
            begin : g_cell
                tilt_div_cell #(
                    .NUM_W (NUM_W),
                    .Q_W   (QB),
                    .STEP  (QB - 1 - gj)
                ) u_cell (
                    .clk     (clk),
                    .rem_in  (dv_rem[gj][gl]),
                    .q_in    (dv_q[gj][gl]),
                    .rem_reg (dv_rem[gj+1][gl]),
                    .q_reg   (dv_q[gj+1][gl])
                );
            end
        end
    endgenerate

    // saturate the magnitude to the 16-bit field
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            mag[l] = (32'(dv_q[QB][l]) > 32'd32767) ? 16'd32767 : 16'(dv_q[QB][l]);
        end
    end

    // output stage: sign of the axis, all-zero sample forced to zero
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (ctl_reg[ST_OUT-1].undef)
            begin
                res_reg[l] <= '0;
            end
            else
            begin
                res_reg[l] <= ctl_reg[ST_OUT-1].neg[l] ? 16'd0 - mag[l] : mag[l];
            end
        end
        undef_reg <= ctl_reg[ST_OUT-1].undef;
    end

    assign done           = ctl_reg[ST_OUT].vld;
    assign tilt_x         = res_reg[0];
    assign tilt_y         = res_reg[1];
    assign tilt_z         = res_reg[2];
    assign undefined_flag = undef_reg;

endmodule
